// ===== design/acgs_pkg.sv =====
package acgs_pkg;

   localparam int GRID_DIM   = 128;
   localparam int POS_W      = 7;
   localparam int LIM_W      = 8;
   localparam int ADDR_W     = 2 * POS_W;
   localparam int CELL_W     = 5;
   localparam int KIND_W     = 2;
   localparam int DIR_W      = 4;
   localparam int ACT_W      = 2;
   localparam int RAD_W      = 2;
   localparam int SPAN_W     = 3;
   localparam int CNT_W      = 6;
   localparam int RND_W      = 16;
   localparam int SQ_W       = 12;
   localparam int DEN_W      = 12;
   localparam int WIDE_W     = 28;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int MOD_STEP_W = 3;

   localparam logic [LIM_W-1:0]  GRID_LIMIT   = LIM_W'(GRID_DIM);
   localparam logic [RAD_W-1:0]  MAX_RADIUS   = 2'd3;
   localparam logic [RND_W-1:0]  PROB_GAIN    = 16'd65503;
   localparam logic [RND_W-1:0]  PROB_FLOOR   = 16'd16;
   localparam logic [RND_W-1:0]  RND_MAX      = 16'hFFFF;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

   localparam logic [DIR_W-1:0] DIR_UP         = 4'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd3;
   localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd4;
   localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd5;
   localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd6;
   localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd7;

   localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_PICK = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DROP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd2;

   typedef struct packed {
      logic             start;
      logic             drop;
      logic [CNT_W-1:0] count;
      logic [RAD_W-1:0] rad;
      logic [RND_W-1:0] rnd;
   } prob_req_type;

   typedef struct packed {
      logic done;
      logic hit;
   } prob_rsp_type;

   // Square of the window cell count less one, the probability denominator.
   function automatic logic [DEN_W-1:0] den_of(input logic [RAD_W-1:0] rad);
      logic [DEN_W-1:0] den;
      unique case (rad)
         2'd1: den = 12'd64;
         2'd2: den = 12'd576;
         default: den = 12'd2304;
      endcase
      return den;
   endfunction

   function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] pos,
                                                 input logic [LIM_W-1:0] lim);
      logic [LIM_W-1:0] nxt;
      nxt = {1'b0, pos} + 8'd1;
      return (nxt == lim) ? '0 : nxt[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] wrap_dec(input logic [POS_W-1:0] pos,
                                                 input logic [LIM_W-1:0] lim);
      logic [LIM_W-1:0] top;
      top = lim - 8'd1;
      return (pos == '0) ? top[POS_W-1:0] : pos - 7'd1;
   endfunction

endpackage

// ===== design/acgs_grid_mem.sv =====
module acgs_grid_mem
   import acgs_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] cells_ff [GRID_DIM*GRID_DIM];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/acgs_mod_unit.sv =====
module acgs_mod_unit
   import acgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [POS_W-1:0] row,
   input  logic [POS_W-1:0] col,
   input  logic [LIM_W-1:0] rows,
   input  logic [LIM_W-1:0] cols,
   output logic             done,
   output logic [POS_W-1:0] row_rem,
   output logic [POS_W-1:0] col_rem
);

   localparam logic [MOD_STEP_W-1:0] TOP_STEP = MOD_STEP_W'(POS_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [MOD_STEP_W-1:0] step_ff, step_in;
   logic [POS_W-1:0]      rrem_ff, rrem_in;
   logic [POS_W-1:0]      crem_ff, crem_in;
   logic [ADDR_W-1:0]     rdiv;
   logic [ADDR_W-1:0]     cdiv;

   // One quotient bit per cycle for both coordinates.
   always_comb begin
      rdiv    = ADDR_W'(rows) << step_ff;
      cdiv    = ADDR_W'(cols) << step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rrem_in = rrem_ff;
      crem_in = crem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = TOP_STEP;
         rrem_in = row;
         crem_in = col;
      end else if (busy_ff) begin
         if (ADDR_W'(rrem_ff) >= rdiv) begin
            rrem_in = rrem_ff - rdiv[POS_W-1:0];
         end
         if (ADDR_W'(crem_ff) >= cdiv) begin
            crem_in = crem_ff - cdiv[POS_W-1:0];
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rrem_ff <= rrem_in;
      crem_ff <= crem_in;
   end

   assign done    = done_ff;
   assign row_rem = rrem_ff;
   assign col_rem = crem_ff;

endmodule

// ===== design/acgs_prob_unit.sv =====
module acgs_prob_unit
   import acgs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  prob_req_type req,
   output prob_rsp_type rsp
);

   logic              v1_ff, v2_ff, done_ff;
   logic              hit_ff, hit_in;
   logic [SQ_W-1:0]   sq_ff;
   logic [WIDE_W-1:0] rhs1_ff, rhs2_ff, rhs_in;
   logic [WIDE_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0]  den;
   logic [DEN_W-2:0]  half_ff;
   logic [RND_W-1:0]  t_val;
   logic              t_ok;
   logic              tok1_ff, tok2_ff;
   logic              drop1_ff, drop2_ff;
   logic              rmax1_ff, rmax2_ff;

   // The test rnd against floor(num/den)+16 becomes a compare of num
   // against (rnd-16)*den for a pick and (rnd-15)*den for a drop.
   always_comb begin
      den = den_of(req.rad);
      if (req.drop) begin
         t_ok  = req.rnd > (PROB_FLOOR - 16'd1);
         t_val = req.rnd - (PROB_FLOOR - 16'd1);
      end else begin
         t_ok  = req.rnd > PROB_FLOOR;
         t_val = req.rnd - PROB_FLOOR;
      end
      rhs_in = WIDE_W'(t_val) * WIDE_W'(den);
      num_in = WIDE_W'(sq_ff) * WIDE_W'(PROB_GAIN) + WIDE_W'(half_ff);
      if (drop2_ff) begin
         hit_in = !rmax2_ff && (!tok2_ff || num_ff >= rhs2_ff);
      end else begin
         hit_in = tok2_ff && num_ff < rhs2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= req.start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
      sq_ff    <= SQ_W'(req.count) * SQ_W'(req.count);
      rhs1_ff  <= rhs_in;
      half_ff  <= den[DEN_W-1:1];
      tok1_ff  <= t_ok;
      drop1_ff <= req.drop;
      rmax1_ff <= req.rnd == RND_MAX;
      num_ff   <= num_in;
      rhs2_ff  <= rhs1_ff;
      tok2_ff  <= tok1_ff;
      drop2_ff <= drop1_ff;
      rmax2_ff <= rmax1_ff;
      hit_ff   <= hit_in;
   end

   assign rsp.done = done_ff;
   assign rsp.hit  = hit_ff;

endmodule

// ===== design/ant_clustering_grid_step_top.sv =====
// Ant clustering grid step. One request beat carries a cell write, a cell
// read or one ant step; every request beat yields exactly one response beat.
// Requests use req_valid/req_stall, responses rsp_valid/rsp_stall, and the
// grid size and vision radius are set through the csr_ write port. The user
// must write them only while the block is idle, which is not enforced.
// After reset the block clears all 16384 grid cells, one per cycle, and
// holds req_stall high until the clear is done.
// A cell write goes from the idle state through ST_FINISH and ST_MOVE to the
// response register; a cell read adds ST_ACCESS for the registered read.
// An ant step skips the window scan when no pick or drop test is due, and
// otherwise reads all (2R+1)^2 window cells for radius 1, 2 or 3.
// Its duration is set by the single read port of the grid memory, which the
// window scan reads one cell per cycle, by a remainder unit that reduces the
// ant position one bit per cycle, and by a three-stage probability compare.
// One item is processed at a time. A finished response sits in the output
// register until taken; the next request is accepted meanwhile, and the
// block only waits when a second response is ready before the first left.
module ant_clustering_grid_step_top
   import acgs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [POS_W-1:0]      req_row,
   input  logic [POS_W-1:0]      req_col,
   input  logic [CELL_W-1:0]     req_item_value,
   input  logic [RND_W-1:0]      req_decision_random,
   input  logic [DIR_W-1:0]      req_move_direction,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_W-1:0]      rsp_new_row,
   output logic [POS_W-1:0]      rsp_new_col,
   output logic [CELL_W-1:0]     rsp_carried_item,
   output logic [CELL_W-1:0]     rsp_cell_value,
   output logic [ACT_W-1:0]      rsp_action,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b00_0000_0001,
      ST_IDLE   = 10'b00_0000_0010,
      ST_ACCESS = 10'b00_0000_0100,
      ST_REDUCE = 10'b00_0000_1000,
      ST_CENTER = 10'b00_0001_0000,
      ST_SCAN   = 10'b00_0010_0000,
      ST_LAST   = 10'b00_0100_0000,
      ST_PROB   = 10'b00_1000_0000,
      ST_FINISH = 10'b01_0000_0000,
      ST_MOVE   = 10'b10_0000_0000
   } state_type;

   state_type          state_ff, state_in;

   logic [LIM_W-1:0]   rows_ff, cols_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [LIM_W-1:0]   rows_eff, cols_eff;
   logic [RAD_W-1:0]   rad_eff;
   logic [SPAN_W-1:0]  span_m1;

   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [CELL_W-1:0]  item_ff, item_in;
   logic [RND_W-1:0]   rnd_ff, rnd_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic [POS_W-1:0]   r0_ff, r0_in, c0_ff, c0_in;
   logic [POS_W-1:0]   srow_ff, srow_in, scol_ff, scol_in;
   logic [POS_W-1:0]   wr_ff, wr_in, wc_ff, wc_in;
   logic [SPAN_W-1:0]  di_ff, di_in, dj_ff, dj_in;
   logic [CELL_W-1:0]  tgt_ff, tgt_in;
   logic               drop_ff, drop_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pstart_ff, pstart_in;

   logic [POS_W-1:0]   res_row_ff, res_row_in, res_col_ff, res_col_in;
   logic [CELL_W-1:0]  res_carry_ff, res_carry_in, res_cell_ff, res_cell_in;
   logic [ACT_W-1:0]   res_act_ff, res_act_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [CELL_W-1:0]  rsp_carry_ff, rsp_carry_in, rsp_cell_ff, rsp_cell_in;
   logic [ACT_W-1:0]   rsp_act_ff, rsp_act_in;

   logic               req_accept;
   logic               mod_start, mod_done;
   logic [POS_W-1:0]   mod_row, mod_col;
   logic [POS_W-1:0]   rdec1, rdec2, rdec3, cdec1, cdec2, cdec3;
   logic [POS_W-1:0]   mv_row, mv_col;

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [CELL_W-1:0]  mem_wdata, mem_rdata;

   prob_req_type       preq;
   prob_rsp_type       prsp;

   acgs_grid_mem u_grid_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   acgs_mod_unit u_mod_unit (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .row     (req_row),
      .col     (req_col),
      .rows    (rows_eff),
      .cols    (cols_eff),
      .done    (mod_done),
      .row_rem (mod_row),
      .col_rem (mod_col)
   );

   acgs_prob_unit u_prob_unit (
      .clock (clock),
      .reset (reset),
      .req   (preq),
      .rsp   (prsp)
   );

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign mod_start  = req_accept && req_kind == KIND_STEP;

   assign preq.start = pstart_ff;
   assign preq.drop  = drop_ff;
   assign preq.count = count_ff;
   assign preq.rad   = rad_eff;
   assign preq.rnd   = rnd_ff;

   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = 8'd1;
      end else if (rows_ff > GRID_LIMIT) begin
         rows_eff = GRID_LIMIT;
      end else begin
         rows_eff = rows_ff;
      end
      if (cols_ff == '0) begin
         cols_eff = 8'd1;
      end else if (cols_ff > GRID_LIMIT) begin
         cols_eff = GRID_LIMIT;
      end else begin
         cols_eff = cols_ff;
      end
      rad_eff = (rad_ff == '0) ? 2'd1 : rad_ff;
      if (rad_eff > MAX_RADIUS) begin
         rad_eff = MAX_RADIUS;
      end
      span_m1 = {rad_eff, 1'b0};
   end

   // Window corner, found by stepping back R places with wrap.
   always_comb begin
      rdec1 = wrap_dec(mod_row, rows_eff);
      rdec2 = wrap_dec(rdec1, rows_eff);
      rdec3 = wrap_dec(rdec2, rows_eff);
      cdec1 = wrap_dec(mod_col, cols_eff);
      cdec2 = wrap_dec(cdec1, cols_eff);
      cdec3 = wrap_dec(cdec2, cols_eff);
   end

   always_comb begin
      mv_row = r0_ff;
      mv_col = c0_ff;
      unique case (dir_ff)
         DIR_UP: begin
            mv_row = wrap_dec(r0_ff, rows_eff);
         end
         DIR_RIGHT: begin
            mv_col = wrap_inc(c0_ff, cols_eff);
         end
         DIR_DOWN: begin
            mv_row = wrap_inc(r0_ff, rows_eff);
         end
         DIR_LEFT: begin
            mv_col = wrap_dec(c0_ff, cols_eff);
         end
         DIR_UP_LEFT: begin
            mv_row = wrap_dec(r0_ff, rows_eff);
            mv_col = wrap_dec(c0_ff, cols_eff);
         end
         DIR_UP_RIGHT: begin
            mv_row = wrap_dec(r0_ff, rows_eff);
            mv_col = wrap_inc(c0_ff, cols_eff);
         end
         DIR_DOWN_RIGHT: begin
            mv_row = wrap_inc(r0_ff, rows_eff);
            mv_col = wrap_inc(c0_ff, cols_eff);
         end
         DIR_DOWN_LEFT: begin
            mv_row = wrap_inc(r0_ff, rows_eff);
            mv_col = wrap_dec(c0_ff, cols_eff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      rnd_in       = rnd_ff;
      dir_in       = dir_ff;
      r0_in        = r0_ff;
      c0_in        = c0_ff;
      srow_in      = srow_ff;
      scol_in      = scol_ff;
      wr_in        = wr_ff;
      wc_in        = wc_ff;
      di_in        = di_ff;
      dj_in        = dj_ff;
      tgt_in       = tgt_ff;
      drop_in      = drop_ff;
      count_in     = count_ff;
      pstart_in    = 1'b0;
      pend_in      = state_ff == ST_SCAN;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      res_carry_in = res_carry_ff;
      res_cell_in  = res_cell_ff;
      res_act_in   = res_act_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_carry_in = rsp_carry_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_act_in   = rsp_act_ff;
      mem_we       = 1'b0;
      mem_waddr    = {r0_ff, c0_ff};
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = {wr_ff, wc_ff};

      if (pend_ff && mem_rdata == tgt_ff) begin
         count_in = count_ff + 6'd1;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 14'd1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               item_in      = req_item_value;
               rnd_in       = req_decision_random;
               dir_in       = req_move_direction;
               res_row_in   = req_row;
               res_col_in   = req_col;
               res_carry_in = '0;
               res_act_in   = ACT_NONE;
               res_cell_in  = req_item_value;
               priority if (req_kind == KIND_STEP) begin
                  state_in = ST_REDUCE;
               end else if (req_kind == KIND_WRITE) begin
                  mem_we    = 1'b1;
                  mem_waddr = {req_row, req_col};
                  mem_wdata = req_item_value;
                  state_in  = ST_FINISH;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = {req_row, req_col};
                  state_in  = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            res_cell_in = mem_rdata;
            state_in    = ST_FINISH;
         end
         ST_REDUCE: begin
            if (mod_done) begin
               r0_in     = mod_row;
               c0_in     = mod_col;
               mem_re    = 1'b1;
               mem_raddr = {mod_row, mod_col};
               unique case (rad_eff)
                  2'd1: begin
                     srow_in = rdec1;
                     scol_in = cdec1;
                  end
                  2'd2: begin
                     srow_in = rdec2;
                     scol_in = cdec2;
                  end
                  default: begin
                     srow_in = rdec3;
                     scol_in = cdec3;
                  end
               endcase
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            res_row_in   = mv_row;
            res_col_in   = mv_col;
            res_carry_in = item_ff;
            res_cell_in  = mem_rdata;
            res_act_in   = ACT_NONE;
            wr_in        = srow_ff;
            wc_in        = scol_ff;
            di_in        = '0;
            dj_in        = '0;
            count_in     = '0;
            if (item_ff == '0 && mem_rdata != '0) begin
               tgt_in   = mem_rdata;
               drop_in  = 1'b0;
               state_in = ST_SCAN;
            end else if (item_ff != '0 && mem_rdata == '0) begin
               tgt_in   = item_ff;
               drop_in  = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            mem_re = 1'b1;
            if (dj_ff == span_m1) begin
               dj_in = '0;
               wc_in = scol_ff;
               di_in = di_ff + 3'd1;
               wr_in = wrap_inc(wr_ff, rows_eff);
               if (di_ff == span_m1) begin
                  state_in = ST_LAST;
               end
            end else begin
               dj_in = dj_ff + 3'd1;
               wc_in = wrap_inc(wc_ff, cols_eff);
            end
         end
         ST_LAST: begin
            pstart_in = 1'b1;
            state_in  = ST_PROB;
         end
         ST_PROB: begin
            if (prsp.done) begin
               if (prsp.hit) begin
                  mem_we = 1'b1;
                  if (drop_ff) begin
                     mem_wdata    = tgt_ff;
                     res_cell_in  = tgt_ff;
                     res_carry_in = '0;
                     res_act_in   = ACT_DROP;
                  end else begin
                     mem_wdata    = '0;
                     res_cell_in  = '0;
                     res_carry_in = tgt_ff;
                     res_act_in   = ACT_PICK;
                  end
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = res_row_ff;
            rsp_col_in   = res_col_ff;
            rsp_carry_in = res_carry_ff;
            rsp_cell_in  = res_cell_ff;
            rsp_act_in   = res_act_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rows_ff      <= 8'd100;
         cols_ff      <= 8'd100;
         rad_ff       <= 2'd1;
         pend_ff      <= 1'b0;
         pstart_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         pstart_ff    <= pstart_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ROWS: begin
                  rows_ff <= csr_wdata;
               end
               CSR_COLS: begin
                  cols_ff <= csr_wdata;
               end
               CSR_RADIUS: begin
                  rad_ff <= csr_wdata[RAD_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      item_ff      <= item_in;
      rnd_ff       <= rnd_in;
      dir_ff       <= dir_in;
      r0_ff        <= r0_in;
      c0_ff        <= c0_in;
      srow_ff      <= srow_in;
      scol_ff      <= scol_in;
      wr_ff        <= wr_in;
      wc_ff        <= wc_in;
      di_ff        <= di_in;
      dj_ff        <= dj_in;
      tgt_ff       <= tgt_in;
      drop_ff      <= drop_in;
      count_ff     <= count_in;
      res_row_ff   <= res_row_in;
      res_col_ff   <= res_col_in;
      res_carry_ff <= res_carry_in;
      res_cell_ff  <= res_cell_in;
      res_act_ff   <= res_act_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_carry_ff <= rsp_carry_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_act_ff   <= rsp_act_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_row      = rsp_row_ff;
   assign rsp_new_col      = rsp_col_ff;
   assign rsp_carried_item = rsp_carry_ff;
   assign rsp_cell_value   = rsp_cell_ff;
   assign rsp_action       = rsp_act_ff;

   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> di_ff <= span_m1 && dj_ff <= span_m1)
      else $error("window scan index beyond window");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN || state_ff == ST_LAST |-> !mem_we)
      else $error("grid written during window scan");

   a_prob_done_in_prob: assert property (@(posedge clock) disable iff (reset)
      prsp.done |-> state_ff == ST_PROB)
      else $error("probability result outside its wait state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE |-> $past(!rsp_valid_ff || !rsp_stall))
      else $error("response register loaded while occupied");

endmodule
